FILE: rtl/tsp_pkg.sv
// Shared types and constants for the transaction stream parser.
// Used by every module of the block; no dependencies.
package tsp_pkg;

    typedef enum logic [3:0] {
        PH_VER,
        PH_INCNT,
        PH_ID,
        PH_PIDX,
        PH_SIGLEN,
        PH_SIG,
        PH_SEQ,
        PH_OUTCNT,
        PH_VALUE,
        PH_PKLEN,
        PH_PK,
        PH_LOCK,
        PH_PAYLEN,
        PH_PAY,
        PH_FINISHED,
        PH_SKIP
    } t_phase;

    typedef enum logic [4:0] {
        K_VERSION    = 5'd0,
        K_TYPE       = 5'd1,
        K_IN_COUNT   = 5'd2,
        K_ID_BYTE    = 5'd3,
        K_PREV_INDEX = 5'd4,
        K_SIG_LEN    = 5'd5,
        K_SIG_BYTE   = 5'd6,
        K_SEQUENCE   = 5'd7,
        K_OUT_COUNT  = 5'd8,
        K_VALUE      = 5'd9,
        K_PK_LEN     = 5'd10,
        K_PK_BYTE    = 5'd11,
        K_LOCKTIME   = 5'd12,
        K_PAY_LEN    = 5'd13,
        K_PAY_BYTE   = 5'd14,
        K_DONE       = 5'd15,
        K_ERROR      = 5'd16
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE      = 3'd0,
        E_TRUNCATED = 3'd1,
        E_INPUTS    = 3'd2,
        E_OUTPUTS   = 3'd3,
        E_SCRIPT    = 3'd4,
        E_PAYLOAD   = 3'd5
    } t_err;

    typedef struct packed {
        t_kind        kind;
        logic [63:0]  value;
        logic [7:0]   entry;
        logic [15:0]  byte_num;
        t_err         err;
        logic         last;
    } t_rec;

    typedef struct packed {
        logic         room;
        logic         busy;
    } t_q_status;

    localparam logic [7:0]  VARINT_16 = 8'hFD;
    localparam logic [7:0]  VARINT_32 = 8'hFE;
    localparam logic [15:0] ID_BYTES  = 16'd32;
    localparam int          TDATA_W   = 96;

endpackage

FILE: rtl/tsp_parser.sv
// Byte-wise field decoder: phase, counters and accumulator of the parser.
// Produces up to two records per byte. Depends on tsp_pkg.
module tsp_parser #(
    parameter int MAX_INPUTS  = 16,
    parameter int MAX_OUTPUTS = 16,
    parameter int MAX_SCRIPT  = 1024,
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_byte,
    input  logic          i_eob,
    output tsp_pkg::t_rec o_rec0,
    output tsp_pkg::t_rec o_rec1,
    output logic [1:0]    o_rec_cnt
);
    import tsp_pkg::*;

    t_phase       r_phase, n_phase;
    logic [15:0]  r_bif, n_bif;
    logic [63:0]  r_acc, n_acc;
    logic [1:0]   r_wcode, n_wcode;
    logic [7:0]   r_entry, n_entry;
    logic [7:0]   r_total, n_total;
    logic [15:0]  r_bl, n_bl;
    logic [15:0]  r_type, n_type;
    logic [31:0]  r_cons, n_cons;

    logic [63:0]  fx_acc;
    logic [15:0]  fx_bif;
    logic         fx4_done, fx8_done;
    logic         vi_first, vi_done;
    logic [63:0]  vi_val;
    logic [15:0]  bl_dec;
    logic [1:0]   vi_n_wcode;
    logic [15:0]  vi_n_bl;
    logic [7:0]   entry_inc;
    logic         active;
    logic         data_ph;
    logic         data_end;

    logic         prim_v, type_v, complete, tr_v;
    t_kind        prim_kind;
    logic [63:0]  prim_val;
    logic [7:0]   prim_entry;
    logic [15:0]  prim_bnum;
    t_err         err;
    t_rec         rec_a, rec_b, rec_t;

    assign fx_acc    = r_acc | (64'(i_byte) << {r_bif[2:0], 3'b000});
    assign fx_bif    = r_bif + 16'd1;
    assign fx4_done  = fx_bif >= 16'd4;
    assign fx8_done  = fx_bif >= 16'd8;
    assign vi_first  = r_wcode == 2'd0;
    assign vi_done   = vi_first ? (i_byte < VARINT_16) : (r_bl == 16'd1);
    assign vi_val    = vi_first ? 64'(i_byte) : fx_acc;
    assign bl_dec    = r_bl - 16'd1;
    assign vi_n_wcode = vi_first ? i_byte[1:0] : r_wcode;
    assign vi_n_bl   = !vi_first ? bl_dec :
                       (i_byte == VARINT_16) ? 16'd2 :
                       (i_byte == VARINT_32) ? 16'd4 : 16'd8;
    assign entry_inc = r_entry + 8'd1;
    assign active    = (r_phase != PH_FINISHED) && (r_phase != PH_SKIP);
    assign data_ph   = (r_phase == PH_ID) || (r_phase == PH_SIG) ||
                       (r_phase == PH_PK) || (r_phase == PH_PAY);
    assign data_end  = (r_phase == PH_ID) ? (fx_bif >= ID_BYTES) :
                       (data_ph && bl_dec == 16'd0);

    always_comb begin
        prim_v     = 1'b0;
        prim_kind  = K_VERSION;
        prim_val   = 64'd0;
        prim_entry = 8'd0;
        prim_bnum  = 16'd0;
        type_v     = 1'b0;
        err        = E_NONE;
        complete   = 1'b0;
        unique case (r_phase)
            PH_VER: begin
                if (fx4_done) begin
                    prim_v   = 1'b1;
                    prim_val = 64'(fx_acc[15:0]);
                    type_v   = !i_eob;
                end
            end
            PH_INCNT: begin
                prim_v    = vi_done;
                prim_kind = K_IN_COUNT;
                prim_val  = vi_val;
                if (vi_done && vi_val > 64'(MAX_INPUTS)) err = E_INPUTS;
            end
            PH_ID: begin
                prim_v     = 1'b1;
                prim_kind  = K_ID_BYTE;
                prim_val   = 64'(i_byte);
                prim_entry = r_entry;
                prim_bnum  = r_bif;
            end
            PH_PIDX: begin
                prim_v     = fx4_done;
                prim_kind  = K_PREV_INDEX;
                prim_val   = fx_acc;
                prim_entry = r_entry;
            end
            PH_SIGLEN: begin
                prim_v     = vi_done;
                prim_kind  = K_SIG_LEN;
                prim_val   = vi_val;
                prim_entry = r_entry;
                if (vi_done && vi_val > 64'(MAX_SCRIPT)) err = E_SCRIPT;
            end
            PH_SIG: begin
                prim_v     = 1'b1;
                prim_kind  = K_SIG_BYTE;
                prim_val   = 64'(i_byte);
                prim_entry = r_entry;
                prim_bnum  = r_bif;
            end
            PH_SEQ: begin
                prim_v     = fx4_done;
                prim_kind  = K_SEQUENCE;
                prim_val   = fx_acc;
                prim_entry = r_entry;
            end
            PH_OUTCNT: begin
                prim_v    = vi_done;
                prim_kind = K_OUT_COUNT;
                prim_val  = vi_val;
                if (vi_done && vi_val > 64'(MAX_OUTPUTS)) err = E_OUTPUTS;
            end
            PH_VALUE: begin
                prim_v     = fx8_done;
                prim_kind  = K_VALUE;
                prim_val   = fx_acc;
                prim_entry = r_entry;
            end
            PH_PKLEN: begin
                prim_v     = vi_done;
                prim_kind  = K_PK_LEN;
                prim_val   = vi_val;
                prim_entry = r_entry;
                if (vi_done && vi_val > 64'(MAX_SCRIPT)) err = E_SCRIPT;
            end
            PH_PK: begin
                prim_v     = 1'b1;
                prim_kind  = K_PK_BYTE;
                prim_val   = 64'(i_byte);
                prim_entry = r_entry;
                prim_bnum  = r_bif;
            end
            PH_LOCK: begin
                prim_v    = fx4_done;
                prim_kind = K_LOCKTIME;
                prim_val  = fx_acc;
                complete  = fx4_done && (r_type == 16'd0 || i_eob);
            end
            PH_PAYLEN: begin
                prim_v    = vi_done;
                prim_kind = K_PAY_LEN;
                prim_val  = vi_val;
                if (vi_done && vi_val > 64'(MAX_PAYLOAD)) err = E_PAYLOAD;
                else complete = vi_done && vi_val == 64'd0;
            end
            PH_PAY: begin
                prim_v    = 1'b1;
                prim_kind = K_PAY_BYTE;
                prim_val  = 64'(i_byte);
                prim_bnum = r_bif;
                complete  = r_bl == 16'd1;
            end
            PH_FINISHED, PH_SKIP: begin
                prim_v = 1'b0;
            end
            default: begin
                prim_v = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_bif   = r_bif;
        n_acc   = r_acc;
        n_wcode = r_wcode;
        n_entry = r_entry;
        n_total = r_total;
        n_bl    = r_bl;
        n_type  = r_type;
        n_cons  = r_cons;
        if (i_fire && active) begin
            n_cons = r_cons + 32'd1;
            unique case (r_phase)
                PH_VER, PH_PIDX, PH_SEQ, PH_VALUE, PH_LOCK: begin
                    n_acc = fx_acc;
                    n_bif = fx_bif;
                end
                PH_INCNT, PH_SIGLEN, PH_OUTCNT, PH_PKLEN, PH_PAYLEN: begin
                    n_acc   = vi_first ? 64'd0 : fx_acc;
                    n_bif   = vi_first ? 16'd0 : fx_bif;
                    n_bl    = vi_n_bl;
                    n_wcode = vi_n_wcode;
                end
                PH_ID: begin
                    n_bif = fx_bif;
                end
                PH_SIG, PH_PK, PH_PAY: begin
                    n_bif = fx_bif;
                    n_bl  = bl_dec;
                end
                default: begin
                    n_bif = r_bif;
                end
            endcase
            if ((prim_v && !data_ph) || data_end) begin
                n_acc   = 64'd0;
                n_bif   = 16'd0;
                n_wcode = 2'd0;
                n_bl    = 16'd0;
            end
            unique case (r_phase)
                PH_VER: begin
                    if (fx4_done) begin
                        n_type  = fx_acc[31:16];
                        n_phase = PH_INCNT;
                    end
                end
                PH_INCNT, PH_OUTCNT: begin
                    if (vi_done && err == E_NONE) begin
                        n_total = vi_val[7:0];
                        n_entry = 8'd0;
                        if (r_phase == PH_INCNT)
                            n_phase = (vi_val == 64'd0) ? PH_OUTCNT : PH_ID;
                        else
                            n_phase = (vi_val == 64'd0) ? PH_LOCK : PH_VALUE;
                    end
                end
                PH_ID: begin
                    if (fx_bif >= ID_BYTES) n_phase = PH_PIDX;
                end
                PH_PIDX: begin
                    if (fx4_done) n_phase = PH_SIGLEN;
                end
                PH_SIGLEN: begin
                    if (vi_done && err == E_NONE) begin
                        if (vi_val == 64'd0) begin
                            n_phase = PH_SEQ;
                        end else begin
                            n_bl    = vi_val[15:0];
                            n_phase = PH_SIG;
                        end
                    end
                end
                PH_SIG: begin
                    if (bl_dec == 16'd0) n_phase = PH_SEQ;
                end
                PH_SEQ: begin
                    if (fx4_done) begin
                        n_entry = entry_inc;
                        n_phase = (entry_inc >= r_total) ? PH_OUTCNT : PH_ID;
                    end
                end
                PH_VALUE: begin
                    if (fx8_done) n_phase = PH_PKLEN;
                end
                PH_PKLEN: begin
                    if (vi_done && err == E_NONE) begin
                        if (vi_val == 64'd0) begin
                            n_entry = entry_inc;
                            n_phase = (entry_inc >= r_total) ? PH_LOCK : PH_VALUE;
                        end else begin
                            n_bl    = vi_val[15:0];
                            n_phase = PH_PK;
                        end
                    end
                end
                PH_PK: begin
                    if (bl_dec == 16'd0) begin
                        n_entry = entry_inc;
                        n_phase = (entry_inc >= r_total) ? PH_LOCK : PH_VALUE;
                    end
                end
                PH_LOCK: begin
                    if (fx4_done && !complete) n_phase = PH_PAYLEN;
                end
                PH_PAYLEN: begin
                    if (vi_done && err == E_NONE && vi_val != 64'd0) begin
                        n_bl    = vi_val[15:0];
                        n_phase = PH_PAY;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            if (err != E_NONE)
                n_phase = PH_SKIP;
            else if (complete)
                n_phase = PH_FINISHED;
        end
        if (i_fire && i_eob) begin
            n_phase = PH_VER;
            n_bif   = 16'd0;
            n_acc   = 64'd0;
            n_wcode = 2'd0;
            n_bl    = 16'd0;
            n_entry = 8'd0;
            n_total = 8'd0;
            n_type  = 16'd0;
            n_cons  = 32'd0;
        end
    end

    always_comb begin
        tr_v = active && (err != E_NONE || complete || i_eob);

        rec_a.kind     = prim_kind;
        rec_a.value    = prim_val;
        rec_a.entry    = prim_entry;
        rec_a.byte_num = prim_bnum;
        rec_a.err      = E_NONE;
        rec_a.last     = 1'b0;

        rec_b.kind     = K_TYPE;
        rec_b.value    = 64'(fx_acc[31:16]);
        rec_b.entry    = 8'd0;
        rec_b.byte_num = 16'd0;
        rec_b.err      = E_NONE;
        rec_b.last     = 1'b1;

        rec_t.entry    = 8'd0;
        rec_t.byte_num = 16'd0;
        rec_t.last     = 1'b1;
        if (err != E_NONE) begin
            rec_t.kind  = K_ERROR;
            rec_t.value = 64'd0;
            rec_t.err   = err;
        end else if (complete) begin
            rec_t.kind  = K_DONE;
            rec_t.value = 64'(r_cons + 32'd1);
            rec_t.err   = E_NONE;
        end else begin
            rec_t.kind  = K_ERROR;
            rec_t.value = 64'd0;
            rec_t.err   = E_TRUNCATED;
        end

        if (i_fire && active)
            o_rec_cnt = 2'(prim_v) + 2'(type_v) + 2'(tr_v);
        else
            o_rec_cnt = 2'd0;

        o_rec0      = prim_v ? rec_a : rec_t;
        o_rec0.last = o_rec_cnt == 2'd1;
        o_rec1      = type_v ? rec_b : rec_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VER;
            r_bif   <= 16'd0;
            r_acc   <= 64'd0;
            r_wcode <= 2'd0;
            r_entry <= 8'd0;
            r_total <= 8'd0;
            r_bl    <= 16'd0;
            r_type  <= 16'd0;
            r_cons  <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_acc   <= n_acc;
            r_wcode <= n_wcode;
            r_entry <= n_entry;
            r_total <= n_total;
            r_bl    <= n_bl;
            r_type  <= n_type;
            r_cons  <= n_cons;
        end
    end

endmodule

FILE: rtl/tsp_rec_queue.sv
// Four-entry record queue between the decoder and the output stream.
// Takes up to two records a cycle, gives one. Depends on tsp_pkg.
module tsp_rec_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsp_pkg::t_rec      i_rec0,
    input  tsp_pkg::t_rec      i_rec1,
    input  logic [1:0]         i_push_cnt,
    input  logic               i_pop,
    output tsp_pkg::t_rec      o_rec,
    output tsp_pkg::t_q_status o_status
);
    import tsp_pkg::*;

    t_rec        r_mem [4];
    logic [1:0]  r_wp, n_wp;
    logic [1:0]  r_rp, n_rp;
    logic [2:0]  r_cnt, n_cnt;
    logic        pop;

    assign pop             = i_pop && (r_cnt != 3'd0);
    assign o_rec           = r_mem[r_rp];
    assign o_status.busy   = r_cnt != 3'd0;
    assign o_status.room   = r_cnt <= 3'd2;

    always_comb begin
        n_wp  = r_wp + i_push_cnt;
        n_rp  = r_rp + 2'(pop);
        n_cnt = r_cnt + 3'(i_push_cnt) - 3'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_wp] <= i_rec0;
        if (i_push_cnt == 2'd2) r_mem[r_wp + 2'd1] <= i_rec1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/transaction_stream_parser_core.sv
// Top level of the transaction stream parser: input register, decoder, record queue.
// Depends on tsp_pkg, tsp_parser and tsp_rec_queue.
//
// Takes one byte of a serialized transaction per cycle while the queue has room (tlast on
// the buffer's final byte) and streams out one record per cycle while m_axis_tready is high.
// A byte registers in the input stage, is decoded once the queue has room, and its records
// are written into a four-entry queue whose head drives the output. Most bytes yield at
// most one record, so the sustained rate is one byte per cycle while the output keeps up;
// a byte that yields two records (the version word with its type, or a field that ends
// together with a done or error record) takes an extra output slot, and the output port
// sets the pace. Bytes after a done or error record up to tlast give nothing.
module transaction_stream_parser_core #(
    parameter int MAX_INPUTS  = 16,
    parameter int MAX_OUTPUTS = 16,
    parameter int MAX_SCRIPT  = 1024,
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // [63:0] field_value, [71:64] entry_number,
                                        // [87:72] byte_number, [90:88] error_code
    output logic [4:0]   m_axis_tuser,  // [4:0] record_kind
    output logic         m_axis_tlast
);
    import tsp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eob;
    logic        fire;
    t_rec        rec0, rec1, q_rec;
    logic [1:0]  rec_cnt;
    t_q_status   q_status;

    assign fire          = r_in_valid && q_status.room;
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eob  <= s_axis_tlast;
        end
    end

    tsp_parser #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS),
        .MAX_SCRIPT  (MAX_SCRIPT),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .i_eob     (r_in_eob),
        .o_rec0    (rec0),
        .o_rec1    (rec1),
        .o_rec_cnt (rec_cnt)
    );

    tsp_rec_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec0     (rec0),
        .i_rec1     (rec1),
        .i_push_cnt (rec_cnt),
        .i_pop      (m_axis_tready),
        .o_rec      (q_rec),
        .o_status   (q_status)
    );

    assign m_axis_tvalid = q_status.busy;
    assign m_axis_tdata  = TDATA_W'({q_rec.err, q_rec.byte_num, q_rec.entry, q_rec.value});
    assign m_axis_tuser  = q_rec.kind;
    assign m_axis_tlast  = q_rec.last;

endmodule

FILE: rtl/tsp_checker.sv
// Port-level checks for transaction_stream_parser_core, bound to the top level.
// Depends on tsp_pkg.
module tsp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [4:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import tsp_pkg::*;

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == K_ERROR |-> m_axis_tlast)
        else $error("error item not last of its byte");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == K_DONE |-> m_axis_tlast)
        else $error("done item not last of its byte");

    a_err_code_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != K_ERROR |-> m_axis_tdata[90:88] == 3'd0)
        else $error("error code set on a non-error item");

    a_type_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == K_TYPE |-> m_axis_tlast)
        else $error("type item not last of its byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

endmodule

bind transaction_stream_parser_core tsp_checker u_tsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
